>>> rtl/core/dmx_pkg.sv
// ----------------------------------------------------------------------------
// dmx_pkg
// Shared constants, codes and types of the DMX512 frame receiver.
// ----------------------------------------------------------------------------
package dmx_pkg;

	localparam int SLOT_COUNT = 512;
	localparam int SLOT_AW    = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
	localparam int NEXT_W     = 10;
	localparam int IDX_W      = 9;
	localparam int APB_AW     = 3;
	localparam int APB_DW     = 32;

	typedef enum logic [1:0] {
		ACT_CHAR  = 2'd0,
		ACT_READ  = 2'd1,
		ACT_CLEAR = 2'd2,
		ACT_NONE  = 2'd3
	} action_t;

	localparam logic CFG_IDX_START_CODE = 1'b0;

endpackage

>>> rtl/core/dmx_in_if.sv
// ----------------------------------------------------------------------------
// dmx_in_if
// Request channel of the DMX512 frame receiver.
// ----------------------------------------------------------------------------
interface dmx_in_if;
	logic       valid;
	logic       ready;
	logic [1:0] action;
	logic       break_flag;
	logic [7:0] rx_byte;
	logic [8:0] slot_index;
	logic [7:0] clear_mask;

	modport source (output valid, action, break_flag, rx_byte, slot_index, clear_mask,
		input ready);
	modport sink (input valid, action, break_flag, rx_byte, slot_index, clear_mask,
		output ready);
endinterface

>>> rtl/core/dmx_out_if.sv
// ----------------------------------------------------------------------------
// dmx_out_if
// Result channel of the DMX512 frame receiver.
// ----------------------------------------------------------------------------
interface dmx_out_if;
	logic       valid;
	logic       ready;
	logic [1:0] rx_state;
	logic [7:0] slot_value;
	logic [7:0] refresh_bits;
	logic       frame_done;

	modport source (output valid, rx_state, slot_value, refresh_bits, frame_done,
		input ready);
	modport sink (input valid, rx_state, slot_value, refresh_bits, frame_done,
		output ready);
endinterface

>>> rtl/core/dmx512_frame_receiver_top.sv
// ----------------------------------------------------------------------------
// dmx512_frame_receiver_top
// DMX512 frame receiver with a 512-slot store and refresh flags.
// ----------------------------------------------------------------------------
// Requests arrive on req_in: a received character (break flag and byte), a
// slot read or a refresh-flag clear. Each request yields one result on
// rsp_out with the receive state, the slot value, the refresh flags and a
// frame-done flag. The start code that opens a data frame is written over
// the APB port at address 0 while the block is idle, a duty of the user; the
// block itself does not enforce it. A result passes the synchronous read of
// the slot memory, then the output register. The block accepts one request
// per cycle while req_in.ready is high; the single-port slot memory takes
// one write or one read per request. When rsp_out stalls, the pipeline holds
// and req_in.ready drops once both stages are full. Reset returns the block
// to idle with zero refresh flags; the slot store needs no clearing pass, as
// a fill count marks the written prefix and slots above it read as zero.
// ----------------------------------------------------------------------------
module dmx512_frame_receiver_top (
	input  logic                       clk,
	input  logic                       arst_n,
	dmx_in_if.sink                     req_in,
	dmx_out_if.source                  rsp_out,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [dmx_pkg::APB_AW-1:0] paddr,
	input  logic [dmx_pkg::APB_DW-1:0] pwdata,
	output logic [dmx_pkg::APB_DW-1:0] prdata,
	output logic                       pready
);

	typedef enum logic [1:0] {
		ST_IDLE  = 2'd0,
		ST_BREAK = 2'd1,
		ST_DATA  = 2'd2
	} rx_state_t;

	localparam logic [dmx_pkg::NEXT_W-1:0] SLOT_LIMIT = dmx_pkg::NEXT_W'(dmx_pkg::SLOT_COUNT);

	logic [7:0] slot_mem [dmx_pkg::SLOT_COUNT];

	logic [7:0] start_code;

	rx_state_t                  state_q, state_d;
	logic [dmx_pkg::NEXT_W-1:0] next_q, next_d, next_inc;
	logic [dmx_pkg::NEXT_W-1:0] fill_q, fill_d;
	logic [7:0]                 refresh_q, refresh_d;
	logic                       done_d;
	logic                       mem_we;
	logic                       rd_hit_d;
	logic [dmx_pkg::NEXT_W-1:0] idx_ext;

	logic       accept;
	logic       s1_valid_q;
	logic       s1_adv;
	rx_state_t  state_s1;
	logic [7:0] refresh_s1;
	logic       done_s1;
	logic       rd_hit_s1;
	logic [7:0] rdata_s1;

	logic       out_valid_q;
	logic [1:0] state_s2;
	logic [7:0] value_s2;
	logic [7:0] refresh_s2;
	logic       done_s2;

	dmx_cfg_regs u_cfg (
		.clk        (clk),
		.arst_n     (arst_n),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.prdata     (prdata),
		.pready     (pready),
		.start_code (start_code)
	);

	assign s1_adv       = s1_valid_q && (!out_valid_q || rsp_out.ready);
	assign req_in.ready = !s1_valid_q || s1_adv;
	assign accept       = req_in.valid && req_in.ready;
	assign next_inc     = next_q + 1'b1;
	assign idx_ext      = dmx_pkg::NEXT_W'(req_in.slot_index);

	always_comb begin
		state_d   = state_q;
		next_d    = next_q;
		fill_d    = fill_q;
		refresh_d = refresh_q;
		done_d    = 1'b0;
		mem_we    = 1'b0;
		rd_hit_d  = 1'b0;
		unique case (dmx_pkg::action_t'(req_in.action))
			dmx_pkg::ACT_CHAR: begin
				if (req_in.break_flag) begin
					state_d = ST_BREAK;
				end else if (state_q == ST_BREAK) begin
					if (req_in.rx_byte == start_code) begin
						state_d = ST_DATA;
						next_d  = '0;
					end else begin
						state_d = ST_IDLE;
					end
				end else if (state_q == ST_DATA) begin
					if (next_q < SLOT_LIMIT) begin
						mem_we = 1'b1;
						next_d = next_inc;
						if (next_inc > fill_q) begin
							fill_d = next_inc;
						end
					end
					refresh_d = 8'hFF;
					if (next_d >= SLOT_LIMIT || next_d == '0) begin
						state_d = ST_IDLE;
						done_d  = 1'b1;
					end
				end
			end
			dmx_pkg::ACT_READ: begin
				rd_hit_d = (idx_ext < SLOT_LIMIT) && (idx_ext < fill_q);
			end
			dmx_pkg::ACT_CLEAR: begin
				refresh_d = refresh_q & ~req_in.clear_mask;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			if (mem_we) begin
				slot_mem[next_q[dmx_pkg::SLOT_AW-1:0]] <= req_in.rx_byte;
			end else begin
				rdata_s1 <= slot_mem[req_in.slot_index[dmx_pkg::SLOT_AW-1:0]];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			next_q      <= '0;
			fill_q      <= '0;
			refresh_q   <= 8'h00;
			s1_valid_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				state_q   <= state_d;
				next_q    <= next_d;
				fill_q    <= fill_d;
				refresh_q <= refresh_d;
			end
			if (accept) begin
				s1_valid_q <= 1'b1;
			end else if (s1_adv) begin
				s1_valid_q <= 1'b0;
			end
			if (s1_adv) begin
				out_valid_q <= 1'b1;
			end else if (rsp_out.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			state_s1   <= state_d;
			refresh_s1 <= refresh_d;
			done_s1    <= done_d;
			rd_hit_s1  <= rd_hit_d;
		end
		if (s1_adv) begin
			state_s2   <= state_s1;
			value_s2   <= rd_hit_s1 ? rdata_s1 : 8'h00;
			refresh_s2 <= refresh_s1;
			done_s2    <= done_s1;
		end
	end

	assign rsp_out.valid        = out_valid_q;
	assign rsp_out.rx_state     = state_s2;
	assign rsp_out.slot_value   = value_s2;
	assign rsp_out.refresh_bits = refresh_s2;
	assign rsp_out.frame_done   = done_s2;

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_out.valid && rsp_out.frame_done) |-> (rsp_out.rx_state == ST_IDLE))
		else $error("frame done reported outside idle state");

	a_done_refresh: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_out.valid && rsp_out.frame_done) |-> (rsp_out.refresh_bits == 8'hFF))
		else $error("frame done without refresh flags set");

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= SLOT_LIMIT)
		else $error("fill count beyond slot count");

	a_ready_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!req_in.ready |-> (s1_valid_q && out_valid_q && !rsp_out.ready))
		else $error("request side stalled without a full pipeline");

endmodule

>>> rtl/core/dmx_cfg_regs.sv
// ----------------------------------------------------------------------------
// dmx_cfg_regs
// APB register file holding the accepted start code.
// ----------------------------------------------------------------------------
module dmx_cfg_regs (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [dmx_pkg::APB_AW-1:0] paddr,
	input  logic [dmx_pkg::APB_DW-1:0] pwdata,
	output logic [dmx_pkg::APB_DW-1:0] prdata,
	output logic                       pready,
	output logic [7:0]                 start_code
);

	logic [7:0] start_code_q;
	logic       sel_start;

	assign sel_start  = (paddr[dmx_pkg::APB_AW-1] == dmx_pkg::CFG_IDX_START_CODE);
	assign pready     = 1'b1;
	assign start_code = start_code_q;
	assign prdata     = sel_start ? {{(dmx_pkg::APB_DW-8){1'b0}}, start_code_q} : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_code_q <= 8'h00;
		end else if (psel && penable && pwrite && sel_start) begin
			start_code_q <= pwdata[7:0];
		end
	end

endmodule
